/* design/ccr_pkg.sv */
// Shared constants, types and field layout for the closed Catmull-Rom evaluator.
package ccr_pkg;

   localparam int IDX_W      = 4;
   localparam int MAX_POINTS = 2 ** IDX_W;
   localparam int CNT_W      = IDX_W + 1;
   localparam int COORD_W    = 32;
   localparam int AXES       = 3;
   localparam int POINT_W    = AXES * COORD_W;
   localparam int TAPS       = 4;
   localparam int T_W        = 16;
   localparam int ACC_W      = 38;
   localparam int PROD_W     = ACC_W + T_W;
   localparam int ROUND_HALF = 1 << (T_W - 1);
   localparam int COUNT_RESET = 4;
   localparam int LAST_STAGE = 9;

   localparam int IDX_LSB    = 0;
   localparam int X_LSB      = IDX_LSB + IDX_W;
   localparam int U_LSB      = X_LSB + POINT_W;
   localparam int REQ_USED   = U_LSB + T_W;
   localparam int REQ_DATA_W = ((REQ_USED + 7) / 8) * 8;

   localparam int TAN_LSB    = AXES * COORD_W;
   localparam int SEG_LSB    = 2 * AXES * COORD_W;
   localparam int RSP_DATA_W = ((SEG_LSB + IDX_W + 7) / 8) * 8;

   typedef enum logic {
      ACTION_LOAD,
      ACTION_EVAL
   } action_type;

   typedef struct packed {
      action_type           action;
      logic [IDX_W-1:0]     slot;
      logic [POINT_W-1:0]   point;
      logic [IDX_W-1:0]     seg;
      logic [T_W-1:0]       frac;
   } front_type;

   typedef logic [TAPS-1:0][IDX_W-1:0] taps_type;
   typedef logic [LAST_STAGE:1]        stage_vec_type;

endpackage

/* design/closed_catmull_rom_evaluator.sv */
// Top level of the closed uniform Catmull-Rom curve evaluator.
//
//   channel | direction | tdata / tuser                           | transfer when
//   req_    | in        | point slot, x, y, z, curve param / kind | req_tvalid & req_tready
//   rsp_    | out       | pos x y z, tangent x y z, segment       | rsp_tvalid & rsp_tready
//   csr_    | in        | point count                             | csr_wr_en
//
// One item per cycle while rsp_tready does not stall the output; an evaluate passes nine stages to reach rsp_.
// Four replicated point tables give the four neighbor reads side by side.
// A load writes its table slot in the first stage and yields no result.
// Reset clears all stage valids and sets the point count to four; the table is not cleared.
// rsp_tready low holds the output register; earlier stages still close up bubbles.
module closed_catmull_rom_evaluator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ccr_pkg::REQ_DATA_W-1:0]  req_tdata,  // point_index, point_x, point_y, point_z, curve_param
   input  logic                            req_tuser,  // action
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ccr_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // pos_x, pos_y, pos_z, tangent_x, tangent_y, tangent_z, segment
   input  logic                            csr_wr_en,
   input  logic [ccr_pkg::CNT_W-1:0]       csr_wr_data
);
   import ccr_pkg::*;

   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   stage_vec_type             valid_ff;
   stage_vec_type             valid_in;
   stage_vec_type             advance;
   front_type                 st1;
   taps_type                  rd_addr;
   logic                      wr_en;
   logic [POINT_W-1:0]        rd_data [TAPS];
   logic [T_W-1:0]            frac_s2_ff;
   logic [IDX_W-1:0]          seg_ff [2:LAST_STAGE];
   logic [TAPS-1:0][COORD_W-1:0] lane_pts [AXES];
   logic signed [COORD_W-1:0] pos [AXES];
   logic signed [COORD_W-1:0] tangent [AXES];

   always_comb begin
      priority if (csr_wr_data == '0) begin
         count_in = CNT_W'(1);
      end else if (csr_wr_data > CNT_W'(MAX_POINTS)) begin
         count_in = CNT_W'(MAX_POINTS);
      end else begin
         count_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_W'(COUNT_RESET);
      end else if (csr_wr_en) begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      advance[LAST_STAGE] = !valid_ff[LAST_STAGE] || rsp_tready;
      for (int k = LAST_STAGE - 1; k >= 1; k--) begin
         advance[k] = !valid_ff[k] || advance[k + 1];
      end
      valid_in[1] = req_tvalid;
      valid_in[2] = valid_ff[1] && (st1.action == ACTION_EVAL);
      for (int k = 3; k <= LAST_STAGE; k++) begin
         valid_in[k] = valid_ff[k - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= LAST_STAGE; k++) begin
            if (advance[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_tready = advance[1];
   assign rsp_tvalid = valid_ff[LAST_STAGE];

   ccr_front u_front (
      .clock     (clock),
      .advance   (advance[1]),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .count     (count_ff),
      .st1       (st1),
      .rd_addr   (rd_addr)
   );

   assign wr_en = valid_ff[1] && (st1.action == ACTION_LOAD) && advance[2];

   for (genvar g = 0; g < TAPS; g++) begin : g_tap
      ccr_ram #(
         .WIDTH (POINT_W),
         .DEPTH (MAX_POINTS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (st1.slot),
         .wr_data (st1.point),
         .rd_en   (advance[2]),
         .rd_addr (rd_addr[g]),
         .rd_data (rd_data[g])
      );
   end

   always_ff @(posedge clock) begin
      if (advance[2]) begin
         frac_s2_ff <= st1.frac;
         seg_ff[2]  <= st1.seg;
      end
      for (int k = 3; k <= LAST_STAGE; k++) begin
         if (advance[k]) begin
            seg_ff[k] <= seg_ff[k - 1];
         end
      end
   end

   always_comb begin
      for (int c = 0; c < AXES; c++) begin
         for (int k = 0; k < TAPS; k++) begin
            lane_pts[c][k] = rd_data[k][c * COORD_W +: COORD_W];
         end
      end
   end

   for (genvar c = 0; c < AXES; c++) begin : g_axis
      ccr_lane u_lane (
         .clock   (clock),
         .advance (advance),
         .frac    (frac_s2_ff),
         .pts     (lane_pts[c]),
         .pos     (pos[c]),
         .tangent (tangent[c])
      );
   end

   always_comb begin
      rsp_tdata = '0;
      for (int c = 0; c < AXES; c++) begin
         rsp_tdata[c * COORD_W +: COORD_W]           = pos[c];
         rsp_tdata[TAN_LSB + c * COORD_W +: COORD_W] = tangent[c];
      end
      rsp_tdata[SEG_LSB +: IDX_W] = seg_ff[LAST_STAGE];
   end

endmodule

/* design/ccr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ccr_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/ccr_front.sv */
// Input stage: segment and fraction from the curve parameter, and the four wrapped table addresses.
module ccr_front (
   input  logic                            clock,
   input  logic                            advance,
   input  logic                            req_tuser,
   input  logic [ccr_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [ccr_pkg::CNT_W-1:0]       count,
   output ccr_pkg::front_type              st1,
   output ccr_pkg::taps_type               rd_addr
);
   import ccr_pkg::*;

   front_type                st1_ff;
   front_type                st1_in;
   logic [T_W+CNT_W-1:0]     scaled;
   logic [CNT_W-1:0]         last;
   logic [CNT_W-1:0]         next1;
   logic [CNT_W-1:0]         next2;

   always_comb begin
      scaled        = (T_W + CNT_W)'(req_tdata[U_LSB +: T_W]) * (T_W + CNT_W)'(count);
      st1_in.action = action_type'(req_tuser);
      st1_in.slot   = req_tdata[IDX_LSB +: IDX_W];
      st1_in.point  = req_tdata[X_LSB +: POINT_W];
      st1_in.seg    = scaled[T_W +: IDX_W];
      st1_in.frac   = scaled[T_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st1_ff <= st1_in;
      end
   end

   always_comb begin
      last  = count - CNT_W'(1);
      next1 = {1'b0, st1_ff.seg} + CNT_W'(1);
      rd_addr[1] = st1_ff.seg;
      rd_addr[0] = (st1_ff.seg == '0) ? last[IDX_W-1:0] : st1_ff.seg - IDX_W'(1);
      rd_addr[2] = (next1 == count) ? '0 : next1[IDX_W-1:0];
      next2 = {1'b0, rd_addr[2]} + CNT_W'(1);
      rd_addr[3] = (next2 == count) ? '0 : next2[IDX_W-1:0];
   end

   assign st1 = st1_ff;

endmodule

/* design/ccr_lane.sv */
// One coordinate axis: basis coefficients, Horner steps for position and derivative, saturation.
module ccr_lane (
   input  logic                                              clock,
   input  ccr_pkg::stage_vec_type                            advance,
   input  logic [ccr_pkg::T_W-1:0]                           frac,
   input  logic [ccr_pkg::TAPS-1:0][ccr_pkg::COORD_W-1:0]    pts,
   output logic signed [ccr_pkg::COORD_W-1:0]                pos,
   output logic signed [ccr_pkg::COORD_W-1:0]                tangent
);
   import ccr_pkg::*;

   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   function automatic prod_type mul_frac(input acc_type a, input logic [T_W+1:0] f);
      logic signed [ACC_W+T_W+2:0] full;
      full = a * $signed({1'b0, f});
      return full[PROD_W-1:0];
   endfunction

   function automatic acc_type rnd(input prod_type m);
      prod_type sum;
      sum = m + prod_type'(ROUND_HALF);
      return sum[PROD_W-1:T_W];
   endfunction

   function automatic logic signed [COORD_W-1:0] sat(input logic signed [ACC_W-2:0] v);
      logic [ACC_W-COORD_W-1:0] hi;
      hi = v[ACC_W-2:COORD_W-1];
      if (hi == '0 || hi == '1) begin
         return v[COORD_W-1:0];
      end else if (v[ACC_W-2]) begin
         return {1'b1, {(COORD_W - 1){1'b0}}};
      end else begin
         return {1'b0, {(COORD_W - 1){1'b1}}};
      end
   endfunction

   acc_type                 e0, e1, e2, e3;
   acc_type                 coef0_in, coef1_in, coef2_in, coef3_in;
   logic [T_W+1:0]          frac3_in;
   prod_type                psum;
   acc_type                 dsum;
   logic signed [COORD_W-1:0] pos_in;
   logic signed [COORD_W-1:0] tan_in;

   acc_type                 coef0_ff, coef1_ff, coef2_ff, coef3_ff;
   logic [T_W-1:0]          frac_s3_ff;
   logic [T_W+1:0]          frac3_s3_ff;
   prod_type                mp_s4_ff, md_s4_ff;
   acc_type                 coef1_s4_ff, coef2_s4_ff, coef3_s4_ff;
   logic [T_W-1:0]          frac_s4_ff;
   acc_type                 xp_s5_ff, xd_s5_ff, coef2_s5_ff, coef3_s5_ff;
   logic [T_W-1:0]          frac_s5_ff;
   prod_type                mp_s6_ff, md_s6_ff;
   acc_type                 coef2_s6_ff, coef3_s6_ff;
   logic [T_W-1:0]          frac_s6_ff;
   acc_type                 xp_s7_ff, xd_s7_ff, coef3_s7_ff;
   logic [T_W-1:0]          frac_s7_ff;
   prod_type                mp_s8_ff;
   acc_type                 coef3_s8_ff;
   logic signed [COORD_W-1:0] tan_s8_ff;
   logic signed [COORD_W-1:0] pos_ff;
   logic signed [COORD_W-1:0] tan_ff;

   always_comb begin
      e0 = acc_type'($signed(pts[0]));
      e1 = acc_type'($signed(pts[1]));
      e2 = acc_type'($signed(pts[2]));
      e3 = acc_type'($signed(pts[3]));
      coef0_in = (e3 - e0) + ((e1 - e2) <<< 1) + (e1 - e2);
      coef1_in = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
      coef2_in = e2 - e0;
      coef3_in = e1 <<< 1;
      frac3_in = (T_W + 2)'(frac) + ((T_W + 2)'(frac) << 1);
      dsum     = xd_s7_ff + acc_type'(1);
      tan_in   = sat(dsum[ACC_W-1:1]);
      psum     = mp_s8_ff + ((prod_type'(coef3_s8_ff) + prod_type'(1)) <<< T_W)
                 + prod_type'(ROUND_HALF);
      pos_in   = sat(psum[PROD_W-1:T_W+1]);
   end

   always_ff @(posedge clock) begin
      if (advance[3]) begin
         coef0_ff    <= coef0_in;
         coef1_ff    <= coef1_in;
         coef2_ff    <= coef2_in;
         coef3_ff    <= coef3_in;
         frac_s3_ff  <= frac;
         frac3_s3_ff <= frac3_in;
      end
      if (advance[4]) begin
         mp_s4_ff    <= mul_frac(coef0_ff, (T_W + 2)'(frac_s3_ff));
         md_s4_ff    <= mul_frac(coef0_ff, frac3_s3_ff);
         coef1_s4_ff <= coef1_ff;
         coef2_s4_ff <= coef2_ff;
         coef3_s4_ff <= coef3_ff;
         frac_s4_ff  <= frac_s3_ff;
      end
      if (advance[5]) begin
         xp_s5_ff    <= rnd(mp_s4_ff) + coef1_s4_ff;
         xd_s5_ff    <= rnd(md_s4_ff) + (coef1_s4_ff <<< 1);
         coef2_s5_ff <= coef2_s4_ff;
         coef3_s5_ff <= coef3_s4_ff;
         frac_s5_ff  <= frac_s4_ff;
      end
      if (advance[6]) begin
         mp_s6_ff    <= mul_frac(xp_s5_ff, (T_W + 2)'(frac_s5_ff));
         md_s6_ff    <= mul_frac(xd_s5_ff, (T_W + 2)'(frac_s5_ff));
         coef2_s6_ff <= coef2_s5_ff;
         coef3_s6_ff <= coef3_s5_ff;
         frac_s6_ff  <= frac_s5_ff;
      end
      if (advance[7]) begin
         xp_s7_ff    <= rnd(mp_s6_ff) + coef2_s6_ff;
         xd_s7_ff    <= rnd(md_s6_ff) + coef2_s6_ff;
         coef3_s7_ff <= coef3_s6_ff;
         frac_s7_ff  <= frac_s6_ff;
      end
      if (advance[8]) begin
         mp_s8_ff    <= mul_frac(xp_s7_ff, (T_W + 2)'(frac_s7_ff));
         tan_s8_ff   <= tan_in;
         coef3_s8_ff <= coef3_s7_ff;
      end
      if (advance[LAST_STAGE]) begin
         pos_ff <= pos_in;
         tan_ff <= tan_s8_ff;
      end
   end

   assign pos     = pos_ff;
   assign tangent = tan_ff;

endmodule

/* design/ccr_checker.sv */
// Port-level assertions for the curve evaluator, bound to the top level.
module ccr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ccr_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import ccr_pkg::*;

   logic [3:0] pending_ff;
   logic [3:0] pending_in;
   logic       eval_in;
   logic       rsp_out;

   always_comb begin
      eval_in    = req_tvalid && req_tready && (action_type'(req_tuser) == ACTION_EVAL);
      rsp_out    = rsp_tvalid && rsp_tready;
      pending_in = pending_ff + 4'(eval_in) - 4'(rsp_out);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_free_flow: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("input stalled while output can drain");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 4'd0)
      else $error("result without an outstanding evaluate");

endmodule

bind closed_catmull_rom_evaluator ccr_checker u_ccr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
